### rtl/htfd_pkg.sv
// Shared types, constants and the CRC-8 helper for the sensor frame decoder.
// No dependencies.
`default_nettype none

package htfd_pkg;

   // Measurement kind selector codes
   localparam logic OpTemp = 1'b0;
   localparam logic OpHum  = 1'b1;

   localparam logic [7:0]         CrcPoly    = 8'h31;
   localparam logic [7:0]         CrcInit    = 8'h00;
   localparam logic [15:0]        StatusMask = 16'hFFFC;
   localparam logic [14:0]        TempScale  = 15'd17572;
   localparam logic [14:0]        HumScale   = 15'd12500;
   localparam logic signed [15:0] TempOffset = -16'sd4685;
   localparam logic signed [15:0] HumOffset  = -16'sd600;
   localparam logic signed [15:0] HumMax     = 16'sd10000;

   typedef struct packed {
      logic       op;
      logic [7:0] data_high;
      logic [7:0] data_low;
      logic [7:0] check_byte;
   } htfd_frame_type;

   typedef struct packed {
      logic signed [14:0] value;
      logic               crc_ok;
   } htfd_result_type;

   // One byte through the MSB-first CRC-8 shift register.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### rtl/htfd_conv.sv
// Combinational frame decode: CRC-8 check plus fixed-point scaling and clamp.
// Depends on htfd_pkg.
`default_nettype none

module htfd_conv
   import htfd_pkg::*;
(
   input  htfd_frame_type  frame,
   output htfd_result_type result
);

   logic [7:0]         crc;
   logic [15:0]        raw;
   logic [14:0]        scale;
   logic [30:0]        prod;
   logic signed [15:0] offset;
   logic signed [15:0] sum;
   logic signed [15:0] value;
   logic               crc_ok;

   assign crc    = crc8_byte(crc8_byte(CrcInit, frame.data_high), frame.data_low);
   assign crc_ok = (crc == frame.check_byte);
   assign raw    = {frame.data_high, frame.data_low} & StatusMask;

   // one shared multiplier, coefficient picked by measurement kind
   assign scale  = (frame.op == OpHum) ? HumScale : TempScale;
   assign offset = (frame.op == OpHum) ? HumOffset : TempOffset;
   assign prod   = {15'd0, raw} * {16'd0, scale};
   assign sum    = offset + $signed({1'b0, prod[30:16]});

   always_comb begin
      value = sum;
      if (frame.op == OpHum) begin
         priority if (sum < 16'sd0) begin
            value = 16'sd0;
         end else if (sum > HumMax) begin
            value = HumMax;
         end else begin
            value = sum;
         end
      end
   end

   assign result.crc_ok = crc_ok;
   assign result.value  = crc_ok ? value[14:0] : 15'sd0;

endmodule

`default_nettype wire

### rtl/humidity_temp_frame_decoder_core.sv
// Top level of the sensor reply frame decoder: handshake, input and result registers.
// Depends on htfd_pkg and htfd_conv.
`default_nettype none

// Decodes one sensor reply frame per transaction. A frame carries two data
// bytes, a received CRC-8 byte and a kind selector (req_op: 0 temperature,
// 1 relative humidity). The CRC-8 (poly 0x31, init 0, MSB first) is checked
// over data_high then data_low; the two low status bits are cleared from the
// 16-bit raw word, which is scaled to hundredths of a degree C
// (-4685 + 17572*raw/65536) or of a percent RH (-600 + 12500*raw/65536,
// clamped to 0..10000). On a CRC mismatch rsp_crc_ok is low and rsp_value is
// zero. A frame is accepted into the input register, then passes through
// CRC and a single constant multiply into the result register, where
// rsp_valid rises; a full result register holds it back. Throughput is one
// transaction per clock while rsp_ready is high; both stages advance
// together, so a new request is taken in the same cycle a pending result is
// consumed. Frames are independent; no state is kept between them. Reset
// only clears the valid flags.
module humidity_temp_frame_decoder_core
   import htfd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [7:0]         req_data_high,
   input  logic [7:0]         req_data_low,
   input  logic [7:0]         req_check_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [14:0] rsp_value,
   output logic               rsp_crc_ok
);

   logic            in_valid_ff, in_valid_in;
   htfd_frame_type  in_frame_ff;
   logic            out_valid_ff, out_valid_in;
   htfd_result_type out_result_ff;
   htfd_result_type conv_result;
   logic            out_free;
   logic            in_advance;
   logic            req_fire;

   // result slot can load when empty or being drained this cycle
   assign out_free   = !out_valid_ff || rsp_ready;
   assign in_advance = in_valid_ff && out_free;
   assign req_ready  = !in_valid_ff || out_free;
   assign req_fire   = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (in_advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (in_advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_frame_ff.op         <= req_op;
         in_frame_ff.data_high  <= req_data_high;
         in_frame_ff.data_low   <= req_data_low;
         in_frame_ff.check_byte <= req_check_byte;
      end
      if (in_advance) begin
         out_result_ff <= conv_result;
      end
   end

   htfd_conv u_conv (
      .frame  (in_frame_ff),
      .result (conv_result)
   );

   assign rsp_valid  = out_valid_ff;
   assign rsp_value  = out_result_ff.value;
   assign rsp_crc_ok = out_result_ff.crc_ok;

endmodule

`default_nettype wire

### rtl/htfd_checker.sv
// Port-level checks for the frame decoder, bound to the top level.
// Depends on htfd_pkg and humidity_temp_frame_decoder_core.
`default_nettype none

module htfd_checker
   import htfd_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [14:0] rsp_value,
   input logic               rsp_crc_ok
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_crc_ok))
      else $error("stalled result changed");

   // CRC failure forces a zero reading
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_crc_ok |-> rsp_value == 15'sd0)
      else $error("nonzero value on CRC error");

   // readings stay in the decodable range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed({rsp_value[14], rsp_value}) >= TempOffset) &&
                    ($signed({rsp_value[14], rsp_value}) <= 16'sd12885))
      else $error("reading out of range");

endmodule

bind humidity_temp_frame_decoder_core htfd_checker u_htfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_value  (rsp_value),
   .rsp_crc_ok (rsp_crc_ok)
);

`default_nettype wire
